### sv/amahm_pkg.sv
// shared types, constants and helpers of the adc moving-average health monitor
`timescale 1ns / 1ps
package amahm_pkg;

  // window depth and derived widths
  localparam int WINDOW_MAX = 16;
  localparam int WIN_AW     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int NCH        = 4;
  localparam int CH_W       = $clog2(NCH);
  localparam int CODE_W     = 8;
  localparam int MASK_W     = NCH;
  localparam int MV_W       = 13;
  localparam int PROD_W     = MV_W + CODE_W;
  localparam int SUM_W      = MV_W + $clog2(WINDOW_MAX);
  localparam int WLEN_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VREF       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAGND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_THR = 3'd4;

  // reset values and fill level
  localparam logic [MV_W-1:0]   FILL_MV        = 13'd5000;
  localparam logic [MV_W-1:0]   VREF_RST       = 13'd5000;
  localparam logic [MV_W-1:0]   VAGND_RST      = 13'd0;
  localparam logic [WLEN_W-1:0] WLEN_RST       = 5'd5;
  localparam logic [MV_W-1:0]   WATER_THR_RST  = 13'd2100;
  localparam logic [MV_W-1:0]   SUPPLY_THR_RST = 13'd3500;

  // one window row: one millivolt value per channel
  typedef logic [NCH-1:0][MV_W-1:0] row_t;
  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;

  // controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            mul;
    logic            conv;
    logic            acc;
    logic            finish;
    logic [CH_W-1:0] ch;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } stat_t;

  // window length clamped to 1..WINDOW_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [WLEN_W-1:0] w);
    logic [LEN_W-1:0] n;
    if (w == '0) begin
      n = LEN_W'(1);
    end else if (LEN_W'(w) > LEN_W'(WINDOW_MAX)) begin
      n = LEN_W'(WINDOW_MAX);
    end else begin
      n = LEN_W'(w);
    end
    return n;
  endfunction

  // refill sum for a window length
  function automatic logic [SUM_W-1:0] fill_sum(input logic [LEN_W-1:0] n);
    return SUM_W'(FILL_MV) * SUM_W'(n);
  endfunction

endpackage

### sv/adc_moving_average_health_monitor.sv
// top level of the adc moving-average health monitor
//
// Usage: the input channel (in_valid/in_ready) carries one word of four 8-bit
// converter codes and a valid mask; each accepted word yields exactly one
// result word on the output channel (out_valid/out_ready): four windowed
// averages in millivolts plus water, low-voltage and healthy flags.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// Writing window_length refills all windows with 5000 mV. The four channels
// share one multiplier and one bit-serial divider, which gives one quotient
// bit per cycle over the 17-bit running sum. A new word is accepted only
// after the result of the previous word has been loaded for output.
// The output word sits in its own register, so a new word is accepted while
// the previous result still waits; if the receiver stalls, the finished word
// waits in the controller until the output register frees.
// Reset (synchronous, active high) restores register defaults, clears the
// last-value registers, and marks every window row as the 5000 mV fill level.
`timescale 1ns / 1ps
module adc_moving_average_health_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [amahm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amahm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [amahm_pkg::CODE_W-1:0]     water_code,
  input  logic [amahm_pkg::CODE_W-1:0]     supply_a_code,
  input  logic [amahm_pkg::CODE_W-1:0]     supply_b_code,
  input  logic [amahm_pkg::CODE_W-1:0]     supply_c_code,
  input  logic [amahm_pkg::MASK_W-1:0]     valid_mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [amahm_pkg::MV_W-1:0]       water_avg_mv,
  output logic [amahm_pkg::MV_W-1:0]       supply_a_avg_mv,
  output logic [amahm_pkg::MV_W-1:0]       supply_b_avg_mv,
  output logic [amahm_pkg::MV_W-1:0]       supply_c_avg_mv,
  output logic                             water_alarm,
  output logic                             low_voltage_alarm,
  output logic                             healthy
);

  amahm_pkg::cmd_t  cmd;
  amahm_pkg::stat_t stat;

  // sequencer
  amahm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic and storage
  amahm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .stat              (stat),
    .water_code        (water_code),
    .supply_a_code     (supply_a_code),
    .supply_b_code     (supply_b_code),
    .supply_c_code     (supply_c_code),
    .valid_mask        (valid_mask),
    .water_avg_mv      (water_avg_mv),
    .supply_a_avg_mv   (supply_a_avg_mv),
    .supply_b_avg_mv   (supply_b_avg_mv),
    .supply_c_avg_mv   (supply_c_avg_mv),
    .water_alarm       (water_alarm),
    .low_voltage_alarm (low_voltage_alarm),
    .healthy           (healthy)
  );

endmodule

### sv/amahm_div.sv
// restoring divider: running sum by window length, one quotient bit per cycle
`timescale 1ns / 1ps
module amahm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [amahm_pkg::SUM_W-1:0] dividend,
  input  logic [amahm_pkg::LEN_W-1:0] divisor,
  output logic                        done,
  output logic [amahm_pkg::SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(amahm_pkg::SUM_W);

  logic                        busy;
  logic [CNT_W-1:0]            count;
  logic [amahm_pkg::LEN_W-1:0] rem;
  logic [amahm_pkg::LEN_W-1:0] dvs;
  logic [amahm_pkg::LEN_W:0]   rem_sh;
  logic                        take;

  // one restoring step
  assign rem_sh = {rem, quotient[amahm_pkg::SUM_W-1]};
  assign take   = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= CNT_W'(amahm_pkg::SUM_W - 1);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        count <= count - CNT_W'(1);
      end
    end else begin
      done <= 1'b0;
    end
  end

  // shift register holds dividend bits, then quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (take) begin
        rem <= amahm_pkg::LEN_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= amahm_pkg::LEN_W'(rem_sh);
      end
      quotient <= {quotient[amahm_pkg::SUM_W-2:0], take};
    end
  end

endmodule

### sv/amahm_dp.sv
// datapath: config registers, code conversion, window memory, sums and averages
`timescale 1ns / 1ps
module amahm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [amahm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amahm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  amahm_pkg::cmd_t                  cmd,
  output amahm_pkg::stat_t                 stat,
  input  logic [amahm_pkg::CODE_W-1:0]     water_code,
  input  logic [amahm_pkg::CODE_W-1:0]     supply_a_code,
  input  logic [amahm_pkg::CODE_W-1:0]     supply_b_code,
  input  logic [amahm_pkg::CODE_W-1:0]     supply_c_code,
  input  logic [amahm_pkg::MASK_W-1:0]     valid_mask,
  output logic [amahm_pkg::MV_W-1:0]       water_avg_mv,
  output logic [amahm_pkg::MV_W-1:0]       supply_a_avg_mv,
  output logic [amahm_pkg::MV_W-1:0]       supply_b_avg_mv,
  output logic [amahm_pkg::MV_W-1:0]       supply_c_avg_mv,
  output logic                             water_alarm,
  output logic                             low_voltage_alarm,
  output logic                             healthy
);

  // config registers
  logic [amahm_pkg::MV_W-1:0]   vref_mv;
  logic [amahm_pkg::MV_W-1:0]   vagnd_mv;
  logic [amahm_pkg::WLEN_W-1:0] window_length;
  logic [amahm_pkg::MV_W-1:0]   water_thr;
  logic [amahm_pkg::MV_W-1:0]   supply_thr;
  logic [amahm_pkg::LEN_W-1:0]  len;
  logic                         refill;

  // item and channel state
  logic [amahm_pkg::NCH-1:0][amahm_pkg::CODE_W-1:0] codes;
  logic [amahm_pkg::MASK_W-1:0]                     mask;
  logic [amahm_pkg::PROD_W-1:0]                     prod;
  amahm_pkg::row_t                                  last;
  amahm_pkg::row_t                                  avg;
  amahm_pkg::sums_t                                 sums;
  logic [amahm_pkg::WIN_AW-1:0]                     slot;
  logic [amahm_pkg::WINDOW_MAX-1:0]                 row_valid;

  // window memory
  amahm_pkg::row_t mem [amahm_pkg::WINDOW_MAX];
  amahm_pkg::row_t rd_row;
  logic            rd_ok;

  logic                          ge;
  logic [amahm_pkg::MV_W-1:0]    span;
  logic [amahm_pkg::MV_W-1:0]    term;
  logic [amahm_pkg::MV_W-1:0]    conv_mv;
  logic [amahm_pkg::MV_W-1:0]    old_mv;
  logic [amahm_pkg::SUM_W-1:0]   new_sum;
  logic [amahm_pkg::WIN_AW:0]    slot_inc;
  logic                          div_done;
  logic [amahm_pkg::SUM_W-1:0]   quotient;
  logic                          water_al;
  logic                          low_al;

  assign refill = cfg_write && (cfg_index == amahm_pkg::REG_WINDOW_LEN);
  assign len    = amahm_pkg::eff_len(window_length);

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv       <= amahm_pkg::VREF_RST;
      vagnd_mv      <= amahm_pkg::VAGND_RST;
      window_length <= amahm_pkg::WLEN_RST;
      water_thr     <= amahm_pkg::WATER_THR_RST;
      supply_thr    <= amahm_pkg::SUPPLY_THR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        amahm_pkg::REG_VREF:       vref_mv       <= cfg_data;
        amahm_pkg::REG_VAGND:      vagnd_mv      <= cfg_data;
        amahm_pkg::REG_WINDOW_LEN: window_length <= cfg_data[amahm_pkg::WLEN_W-1:0];
        amahm_pkg::REG_WATER_THR:  water_thr     <= cfg_data;
        amahm_pkg::REG_SUPPLY_THR: supply_thr    <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      codes <= {supply_c_code, supply_b_code, supply_a_code, water_code};
      mask  <= valid_mask;
    end
  end

  // span times code, one channel at a time
  assign ge   = vref_mv >= vagnd_mv;
  assign span = ge ? (vref_mv - vagnd_mv) : (vagnd_mv - vref_mv);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= amahm_pkg::PROD_W'(span) * amahm_pkg::PROD_W'(codes[cmd.ch]);
    end
  end

  // offset from ground toward reference, truncated toward zero
  assign term    = prod[amahm_pkg::PROD_W-1:amahm_pkg::CODE_W];
  assign conv_mv = ge ? (vagnd_mv + term) : (vagnd_mv - term);

  // last good value per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      last <= '0;
    end else if (cmd.conv && mask[cmd.ch]) begin
      last[cmd.ch] <= conv_mv;
    end
  end

  // read of the row being replaced; rows not written since refill read as fill level
  always_ff @(posedge clk) begin
    rd_row <= mem[slot];
    rd_ok  <= row_valid[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mem[slot] <= last;
    end
  end

  assign old_mv  = rd_ok ? rd_row[cmd.ch] : amahm_pkg::FILL_MV;
  assign new_sum = sums[cmd.ch] - amahm_pkg::SUM_W'(old_mv)
                   + amahm_pkg::SUM_W'(last[cmd.ch]);

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= {amahm_pkg::NCH{amahm_pkg::fill_sum(amahm_pkg::eff_len(amahm_pkg::WLEN_RST))}};
    end else if (refill) begin
      sums <= {amahm_pkg::NCH{amahm_pkg::fill_sum(
                 amahm_pkg::eff_len(cfg_data[amahm_pkg::WLEN_W-1:0]))}};
    end else if (cmd.acc) begin
      sums[cmd.ch] <= new_sum;
    end
  end

  // ring slot and row valid bits
  assign slot_inc = {1'b0, slot} + (amahm_pkg::WIN_AW + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst || refill) begin
      slot      <= '0;
      row_valid <= '0;
    end else if (cmd.finish) begin
      row_valid[slot] <= 1'b1;
      if (amahm_pkg::LEN_W'(slot_inc) >= len) begin
        slot <= '0;
      end else begin
        slot <= slot_inc[amahm_pkg::WIN_AW-1:0];
      end
    end
  end

  // average of the channel
  amahm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.acc),
    .dividend (new_sum),
    .divisor  (len),
    .done     (div_done),
    .quotient (quotient)
  );

  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (div_done) begin
      avg[cmd.ch] <= quotient[amahm_pkg::MV_W-1:0];
    end
  end

  // result word
  assign water_al = avg[0] < water_thr;
  assign low_al   = (avg[1] < supply_thr) || (avg[2] < supply_thr) || (avg[3] < supply_thr);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      water_avg_mv      <= avg[0];
      supply_a_avg_mv   <= avg[1];
      supply_b_avg_mv   <= avg[2];
      supply_c_avg_mv   <= avg[3];
      water_alarm       <= water_al;
      low_voltage_alarm <= low_al;
      healthy           <= !water_al && !low_al;
    end
  end

endmodule

### sv/amahm_ctrl.sv
// controller: sequences the four channels through the shared datapath
`timescale 1ns / 1ps
module amahm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output amahm_pkg::cmd_t  cmd,
  input  amahm_pkg::stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CONV = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [amahm_pkg::CH_W-1:0] ch;
  logic [amahm_pkg::CH_W-1:0] ch_next;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd        = '0;
    cmd.ch     = ch;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          ch_next    = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CONV;
      end
      S_CONV: begin
        cmd.conv   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (ch == amahm_pkg::CH_W'(amahm_pkg::NCH - 1)) begin
            state_next = S_FIN;
          end else begin
            ch_next    = ch + amahm_pkg::CH_W'(1);
            state_next = S_MUL;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // an accepted word starts the first channel
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL && ch == '0))
    else $error("accepted word did not start channel zero");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free)
    else $error("result loaded while output still held");

  // divider completes only while the controller waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == S_DIV)
    else $error("divider done outside divide wait");

  // a loaded result is offered on the next cycle
  a_offer: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("loaded result not offered");

endmodule
